@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 7;
  localparam int PID_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   deq;
    entry_t din;
  } cell_ctl_t;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its entry against the new request
// and takes the new entry or a neighbor's entry on insert or dequeue.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              at_tail,
  input  logic              left_gt,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output spq_pkg::entry_t   entry,
  output logic              gt
);
  import spq_pkg::*;

  entry_t entry_next;

  assign gt = occupied && (entry.prio > ctl.din.prio);

  always_comb begin
    entry_next = entry;
    priority if (ctl.ins) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (gt || at_tail) begin
        entry_next = ctl.din;
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted queue of process entries kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: action selects
//   insert (pid, burst_time, priority_req) or dequeue of the front entry.
//   Output channel (out_valid/out_ready) returns one result per request:
//   the dequeued entry (zero for other requests), status and occupancy.
//   Entries leave in ascending priority number; equal priorities leave in
//   arrival order. Insert when full and dequeue when empty change nothing
//   and report status full or empty.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle; every cell compares its priority
//   with the new request in parallel and shifts in one step.
//   A stalled receiver holds the result; a new request is taken in the
//   same cycle that the waiting result is taken.
//   Reset empties the queue and drops any pending result; cell contents
//   are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [spq_pkg::PID_W-1:0]   pid,
  input  logic [spq_pkg::BURST_W-1:0] burst_time,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spq_pkg::PID_W-1:0]   out_pid,
  output logic [spq_pkg::BURST_W-1:0] out_burst,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic [1:0]                 status,
  output logic [spq_pkg::OCC_W-1:0]   occupancy
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             is_deq;
  cell_ctl_t        ctl;
  entry_t           cells [DEPTH];
  logic [DEPTH-1:0] gt;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign is_deq   = (action == ACT_DEQUEUE);

  assign ctl.ins       = accept && !is_deq && !full;
  assign ctl.deq       = accept && is_deq && !empty;
  assign ctl.din.pid   = pid;
  assign ctl.din.burst = burst_time;
  assign ctl.din.prio  = priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_gt;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_entry = ctl.din;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_entry = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cells[i];
    end else begin : g_mid
      assign right_entry = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count),
      .at_tail     (CNT_W'(i) == count),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cells[i]),
      .gt          (gt[i])
    );
  end

  always_comb begin
    count_next = count;
    priority if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy    <= OCC_W'(count_next);
      out_pid      <= '0;
      out_burst    <= '0;
      out_priority <= '0;
      if (is_deq) begin
        if (empty) begin
          status <= ST_EMPTY;
        end else begin
          status       <= ST_DEQUEUED;
          out_pid      <= cells[0].pid;
          out_burst    <= cells[0].burst;
          out_priority <= cells[0].prio;
        end
      end else begin
        status <= full ? ST_FULL : ST_INSERTED;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_deq && full) |=> (count == $past(count)))
    else $error("rejected insert changed count");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    ctl.deq |=> (count == $past(count) - CNT_W'(1)))
    else $error("dequeue did not drop one entry");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cells[0].prio <= cells[1].prio))
    else $error("front cells out of order");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue. A behavioral queue model
// predicts the result of every request as it is accepted. Each result from
// the block is compared field by field with the oldest prediction.
// Stimulus: directed extremes, fill to full and drain past empty, a long
// receiver hold-off, and random insert/dequeue mixes under several idle and
// stall profiles.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int TIMEOUT_NS  = 5000000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct {
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    status_t            st;
    logic [OCC_W-1:0]   occ;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = 1'b0;
  logic [PID_W-1:0]   pid = '0;
  logic [BURST_W-1:0] burst_time = '0;
  logic [PRIO_W-1:0]  priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PID_W-1:0]   out_pid;
  logic [BURST_W-1:0] out_burst;
  logic [PRIO_W-1:0]  out_priority;
  logic [1:0]         status;
  logic [OCC_W-1:0]   occupancy;

  entry_t  held_entries[$];
  result_t pending_results[$];
  int      err_cnt = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_pulse = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  sorted_priority_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .pid          (pid),
    .burst_time   (burst_time),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pid      (out_pid),
    .out_burst    (out_burst),
    .out_priority (out_priority),
    .status       (status),
    .occupancy    (occupancy)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_pulse != hold_seen) begin
      hold_seen <= hold_pulse;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic apply_request(input action_t act, input entry_t e);
    result_t r;
    entry_t  front;
    int      idx;
    int      i;
    r.pid   = '0;
    r.burst = '0;
    r.prio  = '0;
    if (act == ACT_INSERT) begin
      if (held_entries.size() >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // place behind every entry of equal or lower priority number
        idx = held_entries.size();
        for (i = 0; i < held_entries.size(); i++) begin
          if (held_entries[i].prio > e.prio) begin
            idx = i;
            break;
          end
        end
        held_entries.insert(idx, e);
        r.st = ST_INSERTED;
      end
    end else if (held_entries.size() == 0) begin
      r.st = ST_EMPTY;
    end else begin
      front   = held_entries.pop_front();
      r.pid   = front.pid;
      r.burst = front.burst;
      r.prio  = front.prio;
      r.st    = ST_DEQUEUED;
    end
    r.occ = OCC_W'(held_entries.size());
    pending_results.push_back(r);
  endtask

  task automatic send_request(input action_t act, input logic [PID_W-1:0] p,
                              input logic [BURST_W-1:0] b,
                              input logic [PRIO_W-1:0] pr);
    int     gap;
    entry_t e;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    pid          <= p;
    burst_time   <= b;
    priority_req <= pr;
    do @(posedge clk); while (!in_ready);
    e.pid   = p;
    e.burst = b;
    e.prio  = pr;
    apply_request(act, e);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_pid !== want.pid) begin
          $error("out_pid: expected %0h, actual %0h", want.pid, out_pid);
          err_cnt++;
        end
        if (out_burst !== want.burst) begin
          $error("out_burst: expected %0h, actual %0h", want.burst, out_burst);
          err_cnt++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %0h, actual %0h", want.prio, out_priority);
          err_cnt++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          err_cnt++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
          err_cnt++;
        end
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic test_extremes();
    int i;
    send_request(ACT_DEQUEUE, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(ACT_INSERT, 16'hFFFF, 16'h0000, 8'hFF);
    send_request(ACT_INSERT, 16'h0000, 16'hFFFF, 8'h00);
    send_request(ACT_INSERT, 16'hAAAA, 16'h5555, 8'h80);
    send_request(ACT_INSERT, 16'h5555, 16'hAAAA, 8'h7F);
    send_request(ACT_INSERT, 16'h0001, 16'h0011, 8'h05);
    send_request(ACT_INSERT, 16'h0002, 16'h0022, 8'h05);
    send_request(ACT_INSERT, 16'h0003, 16'h0033, 8'h05);
    send_request(ACT_INSERT, 16'h0004, 16'h0044, 8'hFF);
    for (i = 0; i < 9; i++) send_request(ACT_DEQUEUE, '0, '0, '0);
  endtask

  task automatic test_full_and_empty();
    int i;
    for (i = 0; i < DEPTH; i++)
      send_request(ACT_INSERT, PID_W'($urandom), BURST_W'($urandom),
                   PRIO_W'($urandom_range(7)));
    for (i = 0; i < 3; i++)
      send_request(ACT_INSERT, PID_W'($urandom), BURST_W'($urandom),
                   PRIO_W'($urandom));
    for (i = 0; i < DEPTH + 2; i++)
      send_request(ACT_DEQUEUE, PID_W'($urandom), BURST_W'($urandom),
                   PRIO_W'($urandom));
  endtask

  task automatic test_backpressure();
    int i;
    set_idling(0, 0);
    hold_pulse <= hold_pulse + 1;
    for (i = 0; i < 40; i++)
      send_request((i % 4 == 3) ? ACT_DEQUEUE : ACT_INSERT, PID_W'($urandom),
                   BURST_W'($urandom), PRIO_W'($urandom_range(15)));
  endtask

  task automatic test_random(input int n, input int ins_pct);
    int               i;
    action_t          act;
    logic [PRIO_W-1:0] pr;
    for (i = 0; i < n; i++) begin
      act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_DEQUEUE;
      pr  = ($urandom_range(1) == 0) ? PRIO_W'($urandom_range(3))
                                     : PRIO_W'($urandom);
      send_request(act, PID_W'($urandom), BURST_W'($urandom), pr);
    end
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_full_and_empty();
    test_backpressure();
    set_idling(0, 0);
    test_random(90, 85);
    test_random(90, 15);
    set_idling(85, 0);
    test_random(90, 85);
    test_random(90, 15);
    set_idling(0, 85);
    test_random(90, 85);
    test_random(90, 15);
    set_idling(23, 23);
    test_random(90, 85);
    test_random(90, 15);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
